// ----- hw/rtl/upi_pkg.sv -----
// Shared types, constants and microcode program of the unicycle pose integrator.
package upi_pkg;

  typedef struct packed {
    logic signed [15:0] lin_speed;
    logic signed [19:0] turn_rate;
    logic        [15:0] time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_heading;
  } out_word_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_ITER,
    OP_DIST,
    OP_MLO_X,
    OP_MHI_X,
    OP_ADD_X,
    OP_MLO_Y,
    OP_MHI_Y,
    OP_ADD_Y,
    OP_RATE,
    OP_HEAD,
    OP_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_LOOP
  } ucond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    uop_t            op;
    ucond_t          cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic hold;
    logic loop_more;
  } seq_stat_t;

  localparam logic [PC_W-1:0] PC_WAIT = 4'd0;
  localparam logic [PC_W-1:0] PC_ITER = 4'd1;

  // Control store: one word per step of the item program.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_WAIT,  cond: COND_NEXT,   target: PC_WAIT};
      4'd1:    w = '{op: OP_ITER,  cond: COND_LOOP,   target: PC_ITER};
      4'd2:    w = '{op: OP_DIST,  cond: COND_NEXT,   target: PC_WAIT};
      4'd3:    w = '{op: OP_MLO_X, cond: COND_NEXT,   target: PC_WAIT};
      4'd4:    w = '{op: OP_MHI_X, cond: COND_NEXT,   target: PC_WAIT};
      4'd5:    w = '{op: OP_ADD_X, cond: COND_NEXT,   target: PC_WAIT};
      4'd6:    w = '{op: OP_MLO_Y, cond: COND_NEXT,   target: PC_WAIT};
      4'd7:    w = '{op: OP_MHI_Y, cond: COND_NEXT,   target: PC_WAIT};
      4'd8:    w = '{op: OP_ADD_Y, cond: COND_NEXT,   target: PC_WAIT};
      4'd9:    w = '{op: OP_RATE,  cond: COND_NEXT,   target: PC_WAIT};
      4'd10:   w = '{op: OP_HEAD,  cond: COND_NEXT,   target: PC_WAIT};
      4'd11:   w = '{op: OP_EMIT,  cond: COND_ALWAYS, target: PC_WAIT};
      default: w = '{op: OP_NOP,   cond: COND_ALWAYS, target: PC_WAIT};
    endcase
    return w;
  endfunction

  // Arctangent of 2^-i, full turn = 2^32.
  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IDX_W = 5;

  function automatic logic [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [32:0] QUARTER_TURN    = 33'sd1073741824;
  localparam logic signed [32:0] HALF_TURN       = 33'sd2147483648;

endpackage

// ----- hw/rtl/upi_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jumps.
module upi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  upi_pkg::seq_stat_t  stat,
  output upi_pkg::ctrl_word_t ctrl
);
  import upi_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEXT:   take = 1'b0;
      COND_ALWAYS: take = 1'b1;
      COND_LOOP:   take = stat.loop_more;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (stat.hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hw/rtl/upi_dpath.sv -----
// Datapath: CORDIC registers, shared multiplier, accumulator and pose registers.
module upi_dpath #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  upi_pkg::ctrl_word_t ctrl,
  input  logic                step_en,
  input  upi_pkg::in_word_t   in_data,
  output logic                loop_more,
  output upi_pkg::out_word_t  pose
);
  import upi_pkg::*;

  localparam int ITW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
  localparam logic [ITW-1:0] ITER_LAST = ITW'(TRIG_ITERATIONS - 1);
  localparam int HSHIFT = 32 - ANGLE_BITS;
  localparam logic signed [50:0] HROUND = 51'sd1 <<< (HSHIFT - 1);
  localparam logic signed [63:0] PROUND = 64'sd1 <<< 37;

  logic signed [15:0]  speed_r;
  logic signed [19:0]  rate_r;
  logic        [15:0]  dt_r;
  logic signed [33:0]  x_r, y_r;
  logic signed [32:0]  z_r;
  logic                flip_r;
  logic [ITW-1:0]      iter_r;
  logic signed [32:0]  dist_r;
  logic signed [63:0]  acc_r;
  logic signed [31:0]  pos_x_r, pos_y_r;
  logic signed [ANGLE_BITS-1:0] heading_r;

  logic signed [31:0]  z_init;
  logic signed [32:0]  z_wide;
  logic signed [32:0]  z_start;
  logic                flip_start;
  logic [31:0]         atan_val;

  logic signed [32:0]  mul_a;
  logic signed [17:0]  mul_b;
  logic signed [50:0]  prod;
  logic signed [33:0]  trig_sel;
  logic signed [31:0]  pos_sel;
  logic signed [63:0]  pos_rnd;
  logic signed [63:0]  pos_move;
  logic signed [33:0]  pos_sum;
  logic signed [31:0]  pos_new;
  logic signed [50:0]  head_rnd;
  logic signed [50:0]  head_delta;

  assign loop_more = (iter_r != ITER_LAST);

  // Current heading as a 32-bit binary angle, folded into the right half-plane.
  assign z_init = {heading_r, HSHIFT'(0)};
  assign z_wide = 33'(z_init);

  always_comb begin
    priority if (z_wide > QUARTER_TURN) begin
      z_start    = z_wide - HALF_TURN;
      flip_start = 1'b1;
    end else if (z_wide < -QUARTER_TURN) begin
      z_start    = z_wide + HALF_TURN;
      flip_start = 1'b1;
    end else begin
      z_start    = z_wide;
      flip_start = 1'b0;
    end
  end

  assign atan_val = atan_lut(ATAN_IDX_W'(iter_r));

  assign trig_sel = (ctrl.op == OP_MLO_Y || ctrl.op == OP_MHI_Y) ? y_r : x_r;

  always_comb begin
    unique case (ctrl.op)
      OP_DIST: begin
        mul_a = 33'(speed_r);
        mul_b = $signed({2'b00, dt_r});
      end
      OP_MLO_X, OP_MLO_Y: begin
        mul_a = dist_r;
        mul_b = $signed({1'b0, trig_sel[16:0]});
      end
      OP_MHI_X, OP_MHI_Y: begin
        mul_a = dist_r;
        mul_b = $signed({trig_sel[33], trig_sel[33:17]});
      end
      OP_RATE: begin
        mul_a = 33'(rate_r);
        mul_b = $signed({2'b00, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Round the Q?.54 move to Q16.16, add and saturate.
  assign pos_sel  = (ctrl.op == OP_ADD_Y) ? pos_y_r : pos_x_r;
  assign pos_rnd  = acc_r + PROUND;
  assign pos_move = pos_rnd >>> 38;
  assign pos_sum  = 34'(pos_sel) + pos_move[33:0];

  always_comb begin
    priority if (pos_sum > 34'sd2147483647) begin
      pos_new = 32'sh7FFFFFFF;
    end else if (pos_sum < -34'sd2147483648) begin
      pos_new = 32'sh80000000;
    end else begin
      pos_new = pos_sum[31:0];
    end
  end

  assign head_rnd   = acc_r[50:0] + HROUND;
  assign head_delta = head_rnd >>> HSHIFT;

  always_ff @(posedge clk) begin
    if (step_en) begin
      unique case (ctrl.op)
        OP_WAIT: begin
          speed_r <= in_data.lin_speed;
          rate_r  <= in_data.turn_rate;
          dt_r    <= in_data.time_step;
          x_r     <= CORDIC_GAIN_INV;
          y_r     <= '0;
          z_r     <= z_start;
          flip_r  <= flip_start;
          iter_r  <= '0;
        end
        OP_ITER: begin
          if (!z_r[32]) begin
            x_r <= x_r - (y_r >>> iter_r);
            y_r <= y_r + (x_r >>> iter_r);
            z_r <= z_r - $signed({1'b0, atan_val});
          end else begin
            x_r <= x_r + (y_r >>> iter_r);
            y_r <= y_r - (x_r >>> iter_r);
            z_r <= z_r + $signed({1'b0, atan_val});
          end
          iter_r <= iter_r + 1'b1;
        end
        OP_DIST: begin
          dist_r <= prod[32:0];
          if (flip_r) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
        end
        OP_MLO_X, OP_MLO_Y, OP_RATE: begin
          acc_r <= 64'(prod);
        end
        OP_MHI_X, OP_MHI_Y: begin
          acc_r <= acc_r + (64'(prod) <<< 17);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
    end else if (step_en) begin
      unique case (ctrl.op)
        OP_ADD_X: pos_x_r   <= pos_new;
        OP_ADD_Y: pos_y_r   <= pos_new;
        OP_HEAD:  heading_r <= heading_r + head_delta[ANGLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign pose.out_x = pos_x_r;
  assign pose.out_y = pos_y_r;

  generate
    if (ANGLE_BITS >= 16) begin : g_head_top
      assign pose.out_heading = heading_r[ANGLE_BITS-1 -: 16];
    end else begin : g_head_pad
      assign pose.out_heading = {heading_r, (16 - ANGLE_BITS)'(0)};
    end
  endgenerate

endmodule

// ----- hw/rtl/unicycle_pose_integrator_core.sv -----
// Top level of the unicycle dead-reckoning pose integrator.
// Each accepted word (speed, turn rate, time step) moves the pose by
// speed*dt along the old heading and then turns the heading by rate*dt;
// x and y saturate at the Q16.16 limits and the heading wraps as a binary
// angle. One result word with the new pose follows every input word. Items
// are processed one at a time by a microcoded sequencer: the word is taken,
// the CORDIC iteration loop runs, and the shared 33x18 multiplier then
// computes the distance, the two halves of each axis product and the heading
// increment in turn before the result register is loaded. The result register
// frees the input side, so the next word is taken while a result still waits.
module unicycle_pose_integrator_core #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  upi_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output upi_pkg::out_word_t out_data
);
  import upi_pkg::*;

  ctrl_word_t ctrl;
  seq_stat_t  stat;
  out_word_t  pose;
  logic       loop_more;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_word_t  out_data_r;
  logic       emit;

  assign in_ready = (ctrl.op == OP_WAIT);

  // The program stalls while waiting for a word or for the result slot.
  assign stat.hold = ((ctrl.op == OP_WAIT) && !in_valid) ||
                     ((ctrl.op == OP_EMIT) && out_valid_r && !out_ready);
  assign stat.loop_more = loop_more;

  assign emit = (ctrl.op == OP_EMIT) && !stat.hold;

  upi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  upi_dpath #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .step_en   (!stat.hold),
    .in_data   (in_data),
    .loop_more (loop_more),
    .pose      (pose)
  );

  always_comb begin
    priority if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= pose;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/unicycle_pose_checker.sv -----
// Pose predictor and result checker for the unicycle pose integrator testbench.
module unicycle_pose_checker #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  upi_pkg::in_word_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  upi_pkg::out_word_t        out_data,
  output logic signed [15:0]        heading_now,
  output int                        pending,
  output int                        fail_count
);
  import upi_pkg::*;

  localparam longint GAIN_COMP = 64'sd652032874;
  localparam longint QUARTER   = 64'sd1073741824;
  localparam longint HALF      = 64'sd2147483648;

  longint    pose_x;
  longint    pose_y;
  longint    head_ang;
  out_word_t pose_due[$];
  out_word_t want_word;
  out_word_t next_word;

  function automatic longint arctan_step(input int i);
    case (i)
      0:       return 64'h20000000;
      1:       return 64'h12E4051E;
      2:       return 64'h09FB385B;
      3:       return 64'h051111D4;
      4:       return 64'h028B0D43;
      5:       return 64'h0145D7E1;
      6:       return 64'h00A2F61E;
      7:       return 64'h00517C55;
      8:       return 64'h0028BE53;
      9:       return 64'h00145F2F;
      10:      return 64'h000A2F98;
      11:      return 64'h000517CC;
      12:      return 64'h00028BE6;
      13:      return 64'h000145F3;
      14:      return 64'h0000A2FA;
      15:      return 64'h0000517D;
      16:      return 64'h000028BE;
      17:      return 64'h0000145F;
      18:      return 64'h00000A30;
      19:      return 64'h00000518;
      20:      return 64'h0000028C;
      21:      return 64'h00000146;
      22:      return 64'h000000A3;
      default: return 64'h00000051;
    endcase
  endfunction

  // Sign-extends the low bits of a value, which wraps it as a binary angle.
  function automatic longint wrap_bits(input longint v, input int bits);
    return (v <<< (64 - bits)) >>> (64 - bits);
  endfunction

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Cosine and sine in Q2.30 of an angle where a full turn is 2^32. Angles past
  // a quarter turn are turned by pi first and the results negated.
  function automatic void unit_vector(input longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    bit     flip;
    x    = GAIN_COMP;
    y    = 0;
    z    = ang;
    flip = 1'b0;
    if (z > QUARTER) begin
      z    = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z    = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + arctan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic out_word_t step_pose(input in_word_t w);
    longint    speed;
    longint    rate;
    longint    dt;
    longint    c;
    longint    s;
    longint    travel;
    longint    delta;
    longint    h16;
    out_word_t r;
    speed = $signed(w.lin_speed);
    rate  = $signed(w.turn_rate);
    dt    = w.time_step;
    // The move uses the heading from before this word's turn.
    unit_vector(head_ang <<< (32 - ANGLE_BITS), c, s);
    travel = speed * dt;
    pose_x = sat_q16(pose_x + ((travel * c + (longint'(1) <<< 37)) >>> 38));
    pose_y = sat_q16(pose_y + ((travel * s + (longint'(1) <<< 37)) >>> 38));
    delta  = (rate * dt + (longint'(1) <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
    head_ang = wrap_bits(head_ang + delta, ANGLE_BITS);
    if (ANGLE_BITS >= 16) begin
      h16 = head_ang >>> (ANGLE_BITS - 16);
    end else begin
      h16 = head_ang <<< (16 - ANGLE_BITS);
    end
    r.out_x       = pose_x[31:0];
    r.out_y       = pose_y[31:0];
    r.out_heading = h16[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pose_x   = 0;
      pose_y   = 0;
      head_ang = 0;
      pose_due.delete();
      fail_count = 0;
      heading_now <= '0;
      pending     <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pose_due.size() == 0) begin
          $display("%0t: result word with none expected: actual x=%0d y=%0d heading=%0d",
                   $time, out_data.out_x, out_data.out_y, out_data.out_heading);
          fail_count++;
        end else begin
          want_word = pose_due.pop_front();
          if (out_data.out_x !== want_word.out_x) begin
            $display("%0t: out_x expected %0d actual %0d",
                     $time, want_word.out_x, out_data.out_x);
            fail_count++;
          end
          if (out_data.out_y !== want_word.out_y) begin
            $display("%0t: out_y expected %0d actual %0d",
                     $time, want_word.out_y, out_data.out_y);
            fail_count++;
          end
          if (out_data.out_heading !== want_word.out_heading) begin
            $display("%0t: out_heading expected %0d actual %0d",
                     $time, want_word.out_heading, out_data.out_heading);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        next_word = step_pose(in_data);
        pose_due.push_back(next_word);
        heading_now <= next_word.out_heading;
      end
      pending <= pose_due.size();
    end
  end

endmodule

// ----- verif/unicycle_pose_integrator_core_test.sv -----
// Testbench top for the unicycle pose integrator: clock, reset, stimulus and verdict.
module unicycle_pose_integrator_core_test;
  import upi_pkg::*;

  localparam int ANGLE_BITS      = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int ITEMS_PER_PHASE = 277;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 80;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int                 send_idle_pct = 14;
  int                 recv_idle_pct = 76;
  int                 cycles        = 0;
  int                 sent          = 0;
  int                 pending;
  int                 fail_count;
  logic signed [15:0] heading_now;
  logic signed [15:0] aim           = '0;

  unicycle_pose_integrator_core #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  unicycle_pose_checker #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .heading_now (heading_now),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_word_t make_word(input int speed, input int rate, input int dt);
    in_word_t w;
    w.lin_speed = speed[15:0];
    w.turn_rate = rate[19:0];
    w.time_step = dt[15:0];
    return w;
  endfunction

  // Returns at the edge where the word is taken; valid stays high if the
  // next word follows without a gap.
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // A straight run: a zero time step word settles the known heading, a turn
  // word points the robot at the aim, then many fast words push the pose
  // along it so that the position limits get reached.
  task automatic run_sprint();
    int                 len;
    logic signed [15:0] turn;
    if ($urandom_range(99) < 12) begin
      if ($urandom_range(1) == 0) aim = {2'($urandom_range(3)), 14'd0};
      else aim = 16'($urandom);
    end
    send_word(make_word($urandom, $urandom, 0));
    turn = aim - heading_now;
    send_word(make_word(0, turn, 65535));
    len = $urandom_range(15, 60);
    repeat (len) begin
      send_word(make_word(($urandom_range(99) < 90) ? int'($urandom_range(20000, 32767))
                                                    : -int'($urandom_range(20000, 32768)),
                          int'($urandom_range(6)) - 3,
                          $urandom_range(49152, 65535)));
    end
  endtask

  task automatic run_wander();
    int len;
    int pick;
    int dt;
    len = $urandom_range(4, 30);
    repeat (len) begin
      pick = $urandom_range(9);
      if (pick == 0) dt = 0;
      else if (pick == 1) dt = 65535;
      else dt = $urandom_range(65535);
      send_word(make_word($urandom, $urandom, dt));
    end
  endtask

  initial begin
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Straight moves at full speed both ways, then a half turn that lands
    // exactly on pi and wraps to minus pi, and a move with that heading.
    send_word(make_word(32767, 0, 65535));
    send_word(make_word(-32768, 0, 65535));
    send_word(make_word(0, 32768, 65535));
    send_word(make_word(32767, 0, 65535));
    send_word(make_word(12345, -524288, 65535));
    send_word(make_word(-32768, 524287, 65535));
    // Zero and minimal time steps leave the pose as it was.
    send_word(make_word(32767, 524287, 0));
    send_word(make_word(-32768, -524288, 0));
    send_word(make_word(0, 0, 0));
    send_word(make_word(1, 1, 1));
    send_word(make_word(-1, -1, 1));
    // Quarter turns walk the heading across each quadrant edge.
    send_word(make_word(0, -16384 - 12345, 65535));
    repeat (5) send_word(make_word(25600, 16384, 65535));
    repeat (3) send_word(make_word(-25600, -16384, 65535));
    send_word(make_word(32767, 8192, 65535));
    send_word(make_word(-32768, -1, 65535));
    send_word(make_word(256, 524287, 65535));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = sent + ITEMS_PER_PHASE;
      while (sent < goal) begin
        if ($urandom_range(99) < 50) run_sprint();
        else run_wander();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- unicycle_pose_integrator_core.f -----
hw/rtl/upi_pkg.sv
hw/rtl/upi_seq.sv
hw/rtl/upi_dpath.sv
hw/rtl/unicycle_pose_integrator_core.sv
verif/unicycle_pose_checker.sv
verif/unicycle_pose_integrator_core_test.sv
